### sv/rpn_integer_stack_evaluator_defines.svh
// shared assertion macros for the stack evaluator
`ifndef RPN_INTEGER_STACK_EVALUATOR_DEFINES_SVH
`define RPN_INTEGER_STACK_EVALUATOR_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RISE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define RISE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rise_pkg.sv
package rise_pkg;

    // item kinds
    localparam logic [1:0] FUNC_PUSH_LIT = 2'd0;
    localparam logic [1:0] FUNC_PUSH_VAR = 2'd1;
    localparam logic [1:0] FUNC_APPLY    = 2'd2;

    // operator codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_OVERFLOW   = 3'd1;
    localparam logic [2:0] ST_UNDEF      = 3'd2;
    localparam logic [2:0] ST_FEW        = 3'd3;
    localparam logic [2:0] ST_DIV0       = 3'd4;
    localparam logic [2:0] ST_MOD0       = 3'd5;
    localparam logic [2:0] ST_NOT_SINGLE = 3'd6;
    localparam logic [2:0] ST_UNKNOWN    = 3'd7;

    localparam int unsigned DATA_W = 32;

    // request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } t_alu_ctrl;

    // arithmetic unit status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

endpackage

### sv/rise_alu.sv
module rise_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rise_pkg::t_alu_ctrl i_ctrl,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    output rise_pkg::t_alu_stat o_stat,
    output logic [31:0]         o_result
);
    import rise_pkg::*;

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_FIX
    } t_alu_state;

    t_alu_state  r_state;
    logic        r_done;
    logic [31:0] r_result;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_ub;
    logic [4:0]  r_cnt;
    logic        r_neg_q;
    logic        r_neg_r;
    logic        r_is_mod;

    logic [31:0] a_mag;
    logic [31:0] b_mag;
    logic [31:0] prod;
    logic [32:0] rem_shift;
    logic [32:0] rem_diff;

    // operand magnitudes and the single multiplier (low word only)
    assign a_mag = i_a[31] ? (32'd0 - i_a) : i_a;
    assign b_mag = i_b[31] ? (32'd0 - i_b) : i_b;
    assign prod  = i_a * i_b;

    // one restoring division step
    assign rem_shift = {r_rem, r_quo[31]};
    assign rem_diff  = rem_shift - {1'b0, r_ub};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_ctrl.start) begin
                        case (i_ctrl.op)
                            OP_ADD: begin
                                r_result <= i_a + i_b;
                                r_done   <= 1'b1;
                            end
                            OP_SUB: begin
                                r_result <= i_a - i_b;
                                r_done   <= 1'b1;
                            end
                            OP_MUL: begin
                                r_result <= prod;
                                r_done   <= 1'b1;
                            end
                            default: begin
                                // divide and modulo share the bit-serial divider
                                r_rem    <= 32'd0;
                                r_quo    <= a_mag;
                                r_ub     <= b_mag;
                                r_cnt    <= 5'd31;
                                r_neg_q  <= i_a[31] ^ i_b[31];
                                r_neg_r  <= i_a[31];
                                r_is_mod <= (i_ctrl.op == OP_MOD);
                                r_state  <= A_DIV;
                            end
                        endcase
                    end
                end
                A_DIV: begin
                    if (!rem_diff[32]) begin
                        r_rem <= rem_diff[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= rem_shift[31:0];
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    // quotient truncates toward zero, remainder follows the dividend
                    if (r_is_mod) begin
                        r_result <= r_neg_r ? (32'd0 - r_rem) : r_rem;
                    end else begin
                        r_result <= r_neg_q ? (32'd0 - r_quo) : r_quo;
                    end
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state != A_IDLE);
    assign o_stat.done = r_done;
    assign o_result    = r_result;

endmodule

### sv/rpn_integer_stack_evaluator.sv
// channel   direction  handshake           payload
// item      in         i_valid / o_ready   i_func i_operand_value i_var_defined i_opcode i_last
// result    out        o_valid / i_ready   o_value o_status
//
// pushes write the stack directly; operators use the arithmetic unit (one quotient bit
// per cycle in the shared divider); a last item adds a final read of the bottom entry
// one item is in flight at a time; o_ready is high only while the sequencer is idle
// the result register lets the next item start while a result waits to be taken
// a last item whose result register is still full waits until it drains
// synchronous active-low reset clears the stack pointer, error and handshake state
module rpn_integer_stack_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_operand_value,
    input  logic               i_var_defined,
    input  logic [2:0]         i_opcode,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value,
    output logic [2:0]         o_status
);
    import rise_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_ONE  = SPW'(1);
    localparam logic [SPW-1:0] SP_TWO  = SPW'(2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_B,
        S_RD_A,
        S_OPER,
        S_WAIT,
        S_END,
        S_FETCH0,
        S_EMIT
    } t_state;

    t_state      r_state;
    logic [SPW-1:0] r_sp;
    logic [2:0]  r_err;
    logic [1:0]  r_func;
    logic [31:0] r_val;
    logic        r_def;
    logic [2:0]  r_op;
    logic        r_last;
    logic [31:0] r_b;
    logic [AW-1:0] r_rd_addr;
    logic [31:0] r_rd_data;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic [2:0]  r_out_status;

    logic [DATA_W-1:0] r_stack [STACK_DEPTH];

    logic           push_req;
    logic           push_ok;
    logic           op_known;
    logic           zero_div;
    logic           emit_go;
    logic [SPW-1:0] sp_m1;
    logic [SPW-1:0] sp_m2;
    logic           wr_en;
    logic [31:0]    wr_data;
    t_alu_ctrl      alu_ctrl;
    t_alu_stat      alu_stat;
    logic [31:0]    alu_result;

    // push decode for the held transaction
    assign push_req = (r_func == FUNC_PUSH_LIT) || ((r_func == FUNC_PUSH_VAR) && r_def);
    assign push_ok  = (r_err == ST_OK) && push_req && (r_sp != SP_FULL);
    assign sp_m1    = r_sp - SP_ONE;
    assign sp_m2    = r_sp - SP_TWO;

    // operator checks on the popped operands
    assign op_known = (r_op == OP_ADD) || (r_op == OP_SUB) || (r_op == OP_MUL)
                   || (r_op == OP_DIV) || (r_op == OP_MOD);
    assign zero_div = (r_b == 32'd0) && ((r_op == OP_DIV) || (r_op == OP_MOD));

    // final result goes out once the result register is free
    assign emit_go = (r_state == S_EMIT) && (!r_out_valid || i_ready);

    assign alu_ctrl.start = (r_state == S_OPER) && op_known && !zero_div && !alu_stat.busy;
    assign alu_ctrl.op    = r_op;

    rise_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (alu_ctrl),
        .i_a      (r_rd_data),
        .i_b      (r_b),
        .o_stat   (alu_stat),
        .o_result (alu_result)
    );

    // stack write port: pushes and operator results
    assign wr_en   = ((r_state == S_EXEC) && push_ok) || ((r_state == S_WAIT) && alu_stat.done);
    assign wr_data = (r_state == S_EXEC) ? r_val : alu_result;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[r_sp[AW-1:0]] <= wr_data;
        end
        r_rd_data <= r_stack[r_rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
            r_rd_addr   <= '0;
        end else begin
            // result register: load on emit, clear when taken
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= i_func;
                        r_val   <= i_operand_value;
                        r_def   <= i_var_defined;
                        r_op    <= i_opcode;
                        r_last  <= i_last;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_END;
                    if (r_err == ST_OK) begin
                        case (r_func) inside
                            FUNC_PUSH_LIT, FUNC_PUSH_VAR: begin
                                if ((r_func == FUNC_PUSH_VAR) && !r_def) begin
                                    r_err <= ST_UNDEF;
                                end else if (r_sp == SP_FULL) begin
                                    r_err <= ST_OVERFLOW;
                                end else begin
                                    r_sp <= r_sp + SP_ONE;
                                end
                            end
                            FUNC_APPLY: begin
                                if (r_sp < SP_TWO) begin
                                    r_err <= ST_FEW;
                                end else begin
                                    r_rd_addr <= sp_m1[AW-1:0];
                                    r_state   <= S_RD_B;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD_B: begin
                    r_rd_addr <= sp_m2[AW-1:0];
                    r_state   <= S_RD_A;
                end
                S_RD_A: begin
                    r_b     <= r_rd_data;
                    r_state <= S_OPER;
                end
                S_OPER: begin
                    // lhs is on the read port now; both operands leave the stack
                    r_sp <= sp_m2;
                    if (!op_known) begin
                        r_err   <= ST_UNKNOWN;
                        r_state <= S_END;
                    end else if (zero_div) begin
                        r_err   <= (r_op == OP_DIV) ? ST_DIV0 : ST_MOD0;
                        r_state <= S_END;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (alu_stat.done) begin
                        r_sp    <= r_sp + SP_ONE;
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        if ((r_err == ST_OK) && (r_sp != SP_ONE)) begin
                            r_err <= ST_NOT_SINGLE;
                        end
                        r_rd_addr <= '0;
                        r_state   <= S_FETCH0;
                    end
                end
                S_FETCH0: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // bottom entry is on the read port; wait for a free result slot
                    if (emit_go) begin
                        r_out_value  <= (r_err == ST_OK) ? r_rd_data : 32'd0;
                        r_out_status <= r_err;
                        r_sp         <= '0;
                        r_err        <= ST_OK;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

endmodule

### sv/rise_props.sv
`include "rpn_integer_stack_evaluator_defines.svh"

module rise_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_value,
    input logic [2:0]  o_status
);
    import rise_pkg::*;

    // a waiting result stays offered
    `RISE_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `RISE_ASSERT_NEXT(a_out_stable, o_valid && !i_ready,
        $stable(o_value) && $stable(o_status), "result changed while stalled")

    // a failed expression reports a zero value
    `RISE_ASSERT_IMPL(a_err_zero, o_valid && (o_status != ST_OK),
        o_value == 32'd0, "nonzero value with error status")

    // an accepted transaction keeps the block busy for the next cycle
    `RISE_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready after accept")

endmodule

bind rpn_integer_stack_evaluator rise_props u_rise_props (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_value  (o_value),
    .o_status (o_status)
);
